// ----- hw/rtl/tls_pkg.sv -----
// ----------------------------------------------------------------------------
// tls_pkg
// Shared types, codes and constants for the traffic light sequencer.
// ----------------------------------------------------------------------------
package tls_pkg;

    localparam int TIMER_W       = 16;
    localparam int KEY_W         = 5;
    localparam int LAMP_W        = 16;
    localparam int DIGIT_W       = 12;
    localparam int DIGIT_IDX_W   = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int COUNTDOWN_STEPS_DEF = 12;

    typedef enum logic [2:0] {
        PH_NS_GREEN = 3'd0,
        PH_NS_WAIT  = 3'd1,
        PH_NS_YEL   = 3'd2,
        PH_NS_CROSS = 3'd3,
        PH_EW_GREEN = 3'd4,
        PH_EW_WAIT  = 3'd5,
        PH_EW_YEL   = 3'd6,
        PH_EW_CROSS = 3'd7
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GREEN_MS     = 2'd0,
        CFG_YELLOW_MS    = 2'd1,
        CFG_DIGIT_ON_MS  = 2'd2,
        CFG_DIGIT_OFF_MS = 2'd3
    } cfg_idx_t;

    localparam logic [KEY_W-1:0] KEY_1      = 5'd1;
    localparam logic [KEY_W-1:0] KEY_2      = 5'd2;
    localparam logic [KEY_W-1:0] KEY_3      = 5'd3;
    localparam logic [KEY_W-1:0] KEY_4      = 5'd4;
    localparam logic [KEY_W-1:0] KEY_MODE_0 = 5'd13;
    localparam logic [KEY_W-1:0] KEY_MODE_1 = 5'd14;
    localparam logic [KEY_W-1:0] KEY_WALK   = 5'd16;

    localparam logic [LAMP_W-1:0] LAMP_NS_GREEN  = 16'h8100;
    localparam logic [LAMP_W-1:0] LAMP_NS_YELLOW = 16'h8400;
    localparam logic [LAMP_W-1:0] LAMP_EW_GREEN  = 16'h3000;
    localparam logic [LAMP_W-1:0] LAMP_EW_YELLOW = 16'h5000;
    localparam logic [LAMP_W-1:0] LAMP_CROSSING  = 16'h9000;

    localparam logic [TIMER_W-1:0] GREEN_MS_RST     = 16'd5000;
    localparam logic [TIMER_W-1:0] YELLOW_MS_RST    = 16'd2000;
    localparam logic [TIMER_W-1:0] DIGIT_ON_MS_RST  = 16'd750;
    localparam logic [TIMER_W-1:0] DIGIT_OFF_MS_RST = 16'd250;

    function automatic logic [DIGIT_W-1:0] digit_lookup(input logic [DIGIT_IDX_W-1:0] idx);
        logic [DIGIT_W-1:0] pat;
        unique case (idx)
            4'd0:    pat = 12'hC13;
            4'd1:    pat = 12'hF13;
            4'd2:    pat = 12'h013;
            4'd3:    pat = 12'hF11;
            4'd4:    pat = 12'hD11;
            4'd5:    pat = 12'hC12;
            4'd6:    pat = 12'h913;
            4'd7:    pat = 12'hB03;
            4'd8:    pat = 12'h012;
            default: pat = 12'h713;
        endcase
        return pat;
    endfunction

endpackage

// ----- hw/rtl/tls_if.sv -----
// ----------------------------------------------------------------------------
// tls_if
// Valid/ready channels for sequencer requests and results.
// ----------------------------------------------------------------------------
interface tls_req_if;
    logic                             valid;
    logic                             ready;
    logic                             tick;
    logic                             poll;
    logic [tls_pkg::KEY_W-1:0]        key_code;

    modport source (output valid, output tick, output poll, output key_code, input ready);
    modport sink   (input valid, input tick, input poll, input key_code, output ready);
endinterface

interface tls_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [tls_pkg::LAMP_W-1:0]       lamp_pattern;
    logic [tls_pkg::DIGIT_W-1:0]      digit_pattern;
    logic [2:0]                       phase_now;
    logic                             mode_now;
    logic                             crossing_pending;

    modport source (output valid, output lamp_pattern, output digit_pattern, output phase_now,
                    output mode_now, output crossing_pending, input ready);
    modport sink   (input valid, input lamp_pattern, input digit_pattern, input phase_now,
                    input mode_now, input crossing_pending, output ready);
endinterface

// ----- hw/rtl/traffic_light_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// traffic_light_sequencer_unit
// Two-road light sequencer with waits on keypad polls and a timed pedestrian
// countdown. One result per request.
//
// A request is taken in every cycle in which the result register is empty or
// its content is being taken; the result is registered and appears in the
// cycle after acceptance. One request per clock unless the result stalls, via
// the single state-update stage. The user writes timing registers through
// cfg_we/cfg_index/cfg_data only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module traffic_light_sequencer_unit #(
    parameter int COUNTDOWN_STEPS = tls_pkg::COUNTDOWN_STEPS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    tls_req_if.sink                            request,
    tls_rsp_if.source                          result,
    input  logic                               cfg_we,
    input  logic [tls_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tls_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int TW = tls_pkg::TIMER_W;
    localparam int IW = tls_pkg::DIGIT_IDX_W;
    localparam logic [IW:0] STEPS = (IW+1)'(COUNTDOWN_STEPS);

    logic [TW-1:0] green_ms_reg, yellow_ms_reg, digit_on_ms_reg, digit_off_ms_reg;

    tls_pkg::phase_t phase_reg, phase_next;
    logic [TW-1:0]   tick_count_reg, tick_count_next;
    logic            mode_reg, mode_next;
    logic            crossing_reg, crossing_next;
    logic [IW-1:0]   digit_index_reg, digit_index_next;
    logic            digit_blank_reg, digit_blank_next;

    logic                          out_valid_reg;
    logic [tls_pkg::LAMP_W-1:0]    lamp_reg, lamp_next;
    logic [tls_pkg::DIGIT_W-1:0]   digit_reg, digit_next;
    logic [2:0]                    phase_out_reg;
    logic                          mode_out_reg, crossing_out_reg;

    logic          accept;
    logic [TW-1:0] limit;
    logic [TW:0]   count_inc;
    logic          timer_done;
    logic          wait_exit;
    logic          walk_key;
    logic          mode_after_key;

    assign request.ready = !out_valid_reg || result.ready;
    assign accept        = request.valid && request.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            green_ms_reg     <= tls_pkg::GREEN_MS_RST;
            yellow_ms_reg    <= tls_pkg::YELLOW_MS_RST;
            digit_on_ms_reg  <= tls_pkg::DIGIT_ON_MS_RST;
            digit_off_ms_reg <= tls_pkg::DIGIT_OFF_MS_RST;
        end
        else if (cfg_we)
        begin
            unique case (tls_pkg::cfg_idx_t'(cfg_index))
                tls_pkg::CFG_GREEN_MS:     green_ms_reg     <= cfg_data;
                tls_pkg::CFG_YELLOW_MS:    yellow_ms_reg    <= cfg_data;
                tls_pkg::CFG_DIGIT_ON_MS:  digit_on_ms_reg  <= cfg_data;
                tls_pkg::CFG_DIGIT_OFF_MS: digit_off_ms_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // timer limit for the current phase
    always_comb
    begin
        case (phase_reg)
            tls_pkg::PH_NS_GREEN, tls_pkg::PH_EW_GREEN: limit = green_ms_reg;
            tls_pkg::PH_NS_YEL, tls_pkg::PH_EW_YEL:     limit = yellow_ms_reg;
            default: limit = digit_blank_reg ? digit_off_ms_reg : digit_on_ms_reg;
        endcase
    end

    assign count_inc  = {1'b0, tick_count_reg} + (TW+1)'(1);
    assign timer_done = count_inc >= {1'b0, limit};

    assign walk_key       = request.key_code == tls_pkg::KEY_WALK;
    assign mode_after_key = (request.key_code == tls_pkg::KEY_MODE_0) ? 1'b0 :
                            (request.key_code == tls_pkg::KEY_MODE_1) ? 1'b1 : mode_reg;
    assign wait_exit = mode_after_key || walk_key ||
        ((phase_reg == tls_pkg::PH_NS_WAIT) ?
            (request.key_code == tls_pkg::KEY_3 || request.key_code == tls_pkg::KEY_4) :
            (request.key_code == tls_pkg::KEY_1 || request.key_code == tls_pkg::KEY_2));

    always_comb
    begin
        phase_next       = phase_reg;
        tick_count_next  = tick_count_reg;
        mode_next        = mode_reg;
        crossing_next    = crossing_reg;
        digit_index_next = digit_index_reg;
        digit_blank_next = digit_blank_reg;

        if (accept)
        begin
            unique case (phase_reg)
                tls_pkg::PH_NS_GREEN, tls_pkg::PH_EW_GREEN,
                tls_pkg::PH_NS_YEL, tls_pkg::PH_EW_YEL:
                begin
                    if (request.tick)
                    begin
                        if (timer_done)
                        begin
                            tick_count_next  = '0;
                            digit_index_next = '0;
                            digit_blank_next = 1'b0;
                            if (phase_reg == tls_pkg::PH_NS_GREEN)
                                phase_next = tls_pkg::PH_NS_WAIT;
                            else if (phase_reg == tls_pkg::PH_EW_GREEN)
                                phase_next = tls_pkg::PH_EW_WAIT;
                            else if (phase_reg == tls_pkg::PH_NS_YEL)
                                phase_next = (crossing_reg && !mode_reg) ?
                                             tls_pkg::PH_NS_CROSS : tls_pkg::PH_EW_GREEN;
                            else
                                phase_next = crossing_reg ?
                                             tls_pkg::PH_EW_CROSS : tls_pkg::PH_NS_GREEN;
                        end
                        else
                        begin
                            tick_count_next = count_inc[TW-1:0];
                        end
                    end
                end
                tls_pkg::PH_NS_WAIT, tls_pkg::PH_EW_WAIT:
                begin
                    if (request.poll)
                    begin
                        mode_next = mode_after_key;
                        if (walk_key)
                            crossing_next = 1'b1;
                        if (wait_exit)
                        begin
                            tick_count_next  = '0;
                            digit_index_next = '0;
                            digit_blank_next = 1'b0;
                            phase_next = (phase_reg == tls_pkg::PH_NS_WAIT) ?
                                         tls_pkg::PH_NS_YEL : tls_pkg::PH_EW_YEL;
                        end
                    end
                end
                default:
                begin
                    if (request.tick)
                    begin
                        if (!timer_done)
                        begin
                            tick_count_next = count_inc[TW-1:0];
                        end
                        else
                        begin
                            tick_count_next = '0;
                            if (!digit_blank_reg)
                            begin
                                digit_blank_next = 1'b1;
                            end
                            else if (({1'b0, digit_index_reg} + (IW+1)'(1)) >= STEPS)
                            begin
                                crossing_next    = 1'b0;
                                digit_index_next = '0;
                                digit_blank_next = 1'b0;
                                phase_next = (phase_reg == tls_pkg::PH_NS_CROSS) ?
                                             tls_pkg::PH_EW_GREEN : tls_pkg::PH_NS_GREEN;
                            end
                            else
                            begin
                                digit_blank_next = 1'b0;
                                digit_index_next = digit_index_reg + IW'(1);
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        digit_next = '0;
        case (phase_next)
            tls_pkg::PH_NS_GREEN, tls_pkg::PH_NS_WAIT: lamp_next = tls_pkg::LAMP_NS_GREEN;
            tls_pkg::PH_NS_YEL:                        lamp_next = tls_pkg::LAMP_NS_YELLOW;
            tls_pkg::PH_EW_GREEN, tls_pkg::PH_EW_WAIT: lamp_next = tls_pkg::LAMP_EW_GREEN;
            tls_pkg::PH_EW_YEL:                        lamp_next = tls_pkg::LAMP_EW_YELLOW;
            default:
            begin
                lamp_next = tls_pkg::LAMP_CROSSING;
                if (!digit_blank_next)
                    digit_next = tls_pkg::digit_lookup(digit_index_next);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= tls_pkg::PH_NS_GREEN;
            tick_count_reg  <= '0;
            mode_reg        <= 1'b0;
            crossing_reg    <= 1'b0;
            digit_index_reg <= '0;
            digit_blank_reg <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            tick_count_reg  <= tick_count_next;
            mode_reg        <= mode_next;
            crossing_reg    <= crossing_next;
            digit_index_reg <= digit_index_next;
            digit_blank_reg <= digit_blank_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lamp_reg         <= lamp_next;
            digit_reg        <= digit_next;
            phase_out_reg    <= phase_next;
            mode_out_reg     <= mode_next;
            crossing_out_reg <= crossing_next;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.lamp_pattern     = lamp_reg;
    assign result.digit_pattern    = digit_reg;
    assign result.phase_now        = phase_out_reg;
    assign result.mode_now         = mode_out_reg;
    assign result.crossing_pending = crossing_out_reg;

    // countdown state only moves inside a crossing
    a_digit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !(phase_reg == tls_pkg::PH_NS_CROSS || phase_reg == tls_pkg::PH_EW_CROSS)
        |-> (digit_index_reg == '0 && !digit_blank_reg))
        else $error("countdown state outside crossing");

    // wait phases never hold a running count
    a_wait_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == tls_pkg::PH_NS_WAIT || phase_reg == tls_pkg::PH_EW_WAIT)
        |-> tick_count_reg == '0)
        else $error("tick count running in wait phase");

    // state does not move without an accepted request
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> ($stable(phase_reg) && $stable(mode_reg) && $stable(crossing_reg)))
        else $error("state changed without request");

    // a stalled result blocks new requests
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |-> !request.ready)
        else $error("request taken over stalled result");

    // crossing served after north-south yellow only in sensor mode
    a_ns_cross_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == tls_pkg::PH_NS_YEL && phase_next == tls_pkg::PH_NS_CROSS)
        |-> (!mode_reg && crossing_reg))
        else $error("crossing entered in time mode");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for traffic_light_sequencer_unit. A behavioral model in
// the scoreboard class predicts the lamp, digit, phase, mode and crossing
// outputs for every accepted request. Stimulus is a directed walk through the
// phase ring followed by phase-aware random requests under several timing
// settings and handshake idle mixes.
// ----------------------------------------------------------------------------
module tb;

    localparam int CD_STEPS = tls_pkg::COUNTDOWN_STEPS_DEF;
    localparam logic [tls_pkg::KEY_W-1:0] KEY_NONE = 5'd0;
    localparam logic [tls_pkg::DIGIT_W-1:0] COUNTDOWN_PAT [16] = '{
        12'hC13, 12'hF13, 12'h013, 12'hF11, 12'hD11, 12'hC12, 12'h913, 12'hB03,
        12'h012, 12'h713, 12'h713, 12'h713, 12'h713, 12'h713, 12'h713, 12'h713
    };

    typedef struct packed {
        logic [tls_pkg::LAMP_W-1:0]  lamp;
        logic [tls_pkg::DIGIT_W-1:0] digit;
        logic [2:0]                  phase;
        logic                        mode;
        logic                        pending;
    } light_out_t;

    class light_scoreboard;
        tls_pkg::phase_t             phase;
        int unsigned                 ticks;
        bit                          mode;
        bit                          walk;
        logic [3:0]                  digit_idx;
        bit                          blank;
        logic [tls_pkg::TIMER_W-1:0] green_ms, yellow_ms, on_ms, off_ms;
        light_out_t                  expected_q[$];
        int                          errors;

        function new();
            green_ms  = tls_pkg::GREEN_MS_RST;
            yellow_ms = tls_pkg::YELLOW_MS_RST;
            on_ms     = tls_pkg::DIGIT_ON_MS_RST;
            off_ms    = tls_pkg::DIGIT_OFF_MS_RST;
            mode      = 1'b0;
            walk      = 1'b0;
            errors    = 0;
            enter(tls_pkg::PH_NS_GREEN);
        endfunction

        function void enter(tls_pkg::phase_t p);
            phase     = p;
            ticks     = 0;
            digit_idx = '0;
            blank     = 1'b0;
        endfunction

        function void set_timing(tls_pkg::cfg_idx_t idx, logic [tls_pkg::TIMER_W-1:0] v);
            case (idx)
                tls_pkg::CFG_GREEN_MS:     green_ms  = v;
                tls_pkg::CFG_YELLOW_MS:    yellow_ms = v;
                tls_pkg::CFG_DIGIT_ON_MS:  on_ms     = v;
                tls_pkg::CFG_DIGIT_OFF_MS: off_ms    = v;
                default: ;
            endcase
        endfunction

        function bit interval_done(logic [tls_pkg::TIMER_W-1:0] limit);
            if (ticks + 1 >= 32'(limit)) begin
                ticks = 0;
                return 1'b1;
            end
            ticks++;
            return 1'b0;
        endfunction

        function void poll_wait(logic [tls_pkg::KEY_W-1:0] k, logic [tls_pkg::KEY_W-1:0] car_a,
                                logic [tls_pkg::KEY_W-1:0] car_b, tls_pkg::phase_t nxt);
            if (k == tls_pkg::KEY_MODE_0)
                mode = 1'b0;
            else if (k == tls_pkg::KEY_MODE_1)
                mode = 1'b1;
            if (k == tls_pkg::KEY_WALK)
                walk = 1'b1;
            if (mode || k == tls_pkg::KEY_WALK || k == car_a || k == car_b)
                enter(nxt);
        endfunction

        function void countdown_tick(tls_pkg::phase_t nxt);
            if (!interval_done(blank ? off_ms : on_ms))
                return;
            if (!blank)
                blank = 1'b1;
            else if (int'(digit_idx) + 1 >= CD_STEPS) begin
                walk = 1'b0;
                enter(nxt);
            end
            else begin
                blank = 1'b0;
                digit_idx++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_request(bit t, bit p, logic [tls_pkg::KEY_W-1:0] k);
            light_out_t e;
            case (phase)
                tls_pkg::PH_NS_GREEN:
                    if (t && interval_done(green_ms)) enter(tls_pkg::PH_NS_WAIT);
                tls_pkg::PH_NS_WAIT:
                    if (p) poll_wait(k, tls_pkg::KEY_3, tls_pkg::KEY_4, tls_pkg::PH_NS_YEL);
                tls_pkg::PH_NS_YEL:
                    if (t && interval_done(yellow_ms))
                        enter((walk && !mode) ? tls_pkg::PH_NS_CROSS : tls_pkg::PH_EW_GREEN);
                tls_pkg::PH_NS_CROSS:
                    if (t) countdown_tick(tls_pkg::PH_EW_GREEN);
                tls_pkg::PH_EW_GREEN:
                    if (t && interval_done(green_ms)) enter(tls_pkg::PH_EW_WAIT);
                tls_pkg::PH_EW_WAIT:
                    if (p) poll_wait(k, tls_pkg::KEY_1, tls_pkg::KEY_2, tls_pkg::PH_EW_YEL);
                tls_pkg::PH_EW_YEL:
                    if (t && interval_done(yellow_ms))
                        enter(walk ? tls_pkg::PH_EW_CROSS : tls_pkg::PH_NS_GREEN);
                default:
                    if (t) countdown_tick(tls_pkg::PH_NS_GREEN);
            endcase
            e.digit = '0;
            case (phase)
                tls_pkg::PH_NS_GREEN, tls_pkg::PH_NS_WAIT: e.lamp = tls_pkg::LAMP_NS_GREEN;
                tls_pkg::PH_NS_YEL:                        e.lamp = tls_pkg::LAMP_NS_YELLOW;
                tls_pkg::PH_EW_GREEN, tls_pkg::PH_EW_WAIT: e.lamp = tls_pkg::LAMP_EW_GREEN;
                tls_pkg::PH_EW_YEL:                        e.lamp = tls_pkg::LAMP_EW_YELLOW;
                default:
                begin
                    e.lamp = tls_pkg::LAMP_CROSSING;
                    if (!blank)
                        e.digit = COUNTDOWN_PAT[digit_idx];
                end
            endcase
            e.phase   = phase;
            e.mode    = mode;
            e.pending = walk;
            expected_q.push_back(e);
        endfunction

        function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v) begin
                errors++;
                $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(light_out_t got);
            light_out_t e;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result expected none actual %h", $time, got);
                return;
            end
            e = expected_q.pop_front();
            compare_field("lamp_pattern", 32'(e.lamp), 32'(got.lamp));
            compare_field("digit_pattern", 32'(e.digit), 32'(got.digit));
            compare_field("phase_now", 32'(e.phase), 32'(got.phase));
            compare_field("mode_now", 32'(e.mode), 32'(got.mode));
            compare_field("crossing_pending", 32'(e.pending), 32'(got.pending));
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [tls_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [tls_pkg::CFG_DATA_W-1:0] cfg_data;
    int                             send_idle_pct;
    int                             recv_idle_pct;
    light_scoreboard                sb;

    tls_req_if req_ch();
    tls_rsp_if rsp_ch();

    traffic_light_sequencer_unit #(
        .COUNTDOWN_STEPS(CD_STEPS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (req_ch),
        .result    (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_result({rsp_ch.lamp_pattern, rsp_ch.digit_pattern, rsp_ch.phase_now,
                             rsp_ch.mode_now, rsp_ch.crossing_pending});
    end

    task automatic send_request(input bit t, input bit p, input logic [tls_pkg::KEY_W-1:0] k);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.tick     <= t;
        req_ch.poll     <= p;
        req_ch.key_code <= k;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_request(t, p, k);
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic program_timing(input logic [tls_pkg::TIMER_W-1:0] g, y, on_v, off_v);
        logic [tls_pkg::TIMER_W-1:0] vals [4];
        vals = '{g, y, on_v, off_v};
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= tls_pkg::cfg_idx_t'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            sb.set_timing(tls_pkg::cfg_idx_t'(i), vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // waits see mostly polls with meaningful keys, timed phases mostly ticks
    function automatic void pick_request(output bit t, output bit p,
                                         output logic [tls_pkg::KEY_W-1:0] k);
        int roll;
        roll = $urandom_range(99);
        k    = tls_pkg::KEY_W'($urandom_range(31));
        t    = 1'($urandom_range(1));
        p    = 1'($urandom_range(1));
        if (roll < 10)
            return;
        if (sb.phase == tls_pkg::PH_NS_WAIT || sb.phase == tls_pkg::PH_EW_WAIT) begin
            p    = ($urandom_range(9) != 0);
            roll = $urandom_range(99);
            if (roll < 35) begin
                if (sb.phase == tls_pkg::PH_NS_WAIT)
                    k = $urandom_range(1) ? tls_pkg::KEY_3 : tls_pkg::KEY_4;
                else
                    k = $urandom_range(1) ? tls_pkg::KEY_1 : tls_pkg::KEY_2;
            end
            else if (roll < 50)
                k = tls_pkg::KEY_WALK;
            else if (roll < 60)
                k = tls_pkg::KEY_MODE_0;
            else if (roll < 65)
                k = tls_pkg::KEY_MODE_1;
            else if (roll < 75)
                k = KEY_NONE;
        end
        else
            t = ($urandom_range(9) < 8);
    endfunction

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        bit                          t, p;
        logic [tls_pkg::KEY_W-1:0]   k;
        logic [tls_pkg::TIMER_W-1:0] g, y, on_v, off_v;
        int                          n;
        sb              = new();
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.tick     = 1'b0;
        req_ch.poll     = 1'b0;
        req_ch.key_code = KEY_NONE;
        rsp_ch.ready    = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = tls_pkg::CFG_GREEN_MS;
        cfg_data        = '0;
        send_idle_pct   = 27;
        recv_idle_pct   = 52;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset timing, then lowered mid-phase below the running count
        send_request(1'b1, 1'b0, KEY_NONE);
        send_request(1'b1, 1'b1, tls_pkg::KEY_WALK);
        send_request(1'b1, 1'b0, 5'd31);
        settle();
        program_timing(16'd1, 16'd1, 16'd0, 16'd1);
        send_request(1'b0, 1'b1, tls_pkg::KEY_WALK);
        send_request(1'b1, 1'b0, 5'd31);
        send_request(1'b1, 1'b0, KEY_NONE);
        send_request(1'b0, 1'b1, KEY_NONE);
        send_request(1'b0, 1'b1, 5'd31);
        send_request(1'b0, 1'b1, tls_pkg::KEY_1);
        send_request(1'b0, 1'b1, tls_pkg::KEY_MODE_0);
        send_request(1'b1, 1'b1, tls_pkg::KEY_4);
        send_request(1'b1, 1'b0, KEY_NONE);
        send_request(1'b1, 1'b1, 5'd17);
        send_request(1'b0, 1'b1, tls_pkg::KEY_3);
        send_request(1'b0, 1'b1, tls_pkg::KEY_MODE_1);
        send_request(1'b1, 1'b0, KEY_NONE);
        send_request(1'b1, 1'b0, KEY_NONE);
        send_request(1'b0, 1'b1, tls_pkg::KEY_WALK);
        send_request(1'b1, 1'b0, KEY_NONE);
        send_request(1'b1, 1'b0, KEY_NONE);
        send_request(1'b0, 1'b1, tls_pkg::KEY_MODE_0);
        send_request(1'b0, 1'b1, tls_pkg::KEY_2);
        send_request(1'b1, 1'b0, KEY_NONE);
        send_request(1'b1, 1'b0, KEY_NONE);
        send_request(1'b1, 1'b0, KEY_NONE);
        send_request(1'b0, 1'b1, tls_pkg::KEY_WALK);
        settle();

        for (int regime = 0; regime < 3; regime++) begin
            send_idle_pct = (regime == 0) ? 27 : (regime == 1) ? 52 : 0;
            recv_idle_pct = (regime == 0) ? 52 : (regime == 1) ? 27 : 0;
            for (int s = 0; s < 6; s++) begin
                n = 120;
                case (s)
                    0: {g, y, on_v, off_v} = {16'd1, 16'd1, 16'd1, 16'd1};
                    1: {g, y, on_v, off_v} = '0;
                    2:
                    begin
                        {g, y, on_v, off_v} = '1;
                        n = 40;
                    end
                    3: {g, y, on_v, off_v} = {16'd2, 16'd3, 16'd1, 16'd2};
                    4:
                    begin
                        g     = tls_pkg::TIMER_W'($urandom_range(6, 1));
                        y     = tls_pkg::TIMER_W'($urandom_range(6, 1));
                        on_v  = tls_pkg::TIMER_W'($urandom_range(6, 1));
                        off_v = tls_pkg::TIMER_W'($urandom_range(6, 1));
                    end
                    default:
                    begin
                        g     = tls_pkg::TIMER_W'($urandom_range(4, 1));
                        y     = tls_pkg::TIMER_W'($urandom_range(4, 1));
                        on_v  = tls_pkg::TIMER_W'($urandom_range(4, 1));
                        off_v = tls_pkg::TIMER_W'($urandom_range(4, 1));
                    end
                endcase
                program_timing(g, y, on_v, off_v);
                repeat (n) begin
                    pick_request(t, p, k);
                    send_request(t, p, k);
                end
                settle();
            end
        end

        repeat (4) @(posedge clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/tls_pkg.sv
hw/rtl/tls_if.sv
hw/rtl/traffic_light_sequencer_unit.sv
test/tb.sv
